// ===== hw/rtl/rbc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rbc_pkg
// Shared types and constants for the reconnect backoff controller.
// ============================================================================
package rbc_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W      = 3;
    localparam int BASE_W      = 16;
    localparam int CAP_W       = 20;
    localparam int OUT_DELAY_W = 20;
    localparam int OUT_ATT_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Wide enough for base << 31
    localparam int SHIFT_W     = 48;

    // Register reset values
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd1000;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 20'd30000;

    // Event codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CONNECT    = 3'd0,
        FUNC_USER_DISC  = 3'd1,
        FUNC_LINK_UP    = 3'd2,
        FUNC_LINK_DOWN  = 3'd3,
        FUNC_LINK_ERROR = 3'd4,
        FUNC_TICK       = 3'd5
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE   = 2'd0,
        REG_CAP    = 2'd1,
        REG_ATTACH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [CAP_W-1:0]  cap;
        logic              attached;
    } cfg_t;

    typedef struct packed {
        logic                   waiting;
        logic [OUT_ATT_W-1:0]   attempt_count;
        logic [OUT_DELAY_W-1:0] retry_delay;
        logic                   retry_armed;
        logic                   notify_error;
        logic                   notify_down;
        logic                   notify_up;
        logic                   close_link;
        logic                   open_link;
    } result_t;

endpackage

// ===== hw/rtl/reconnect_backoff_controller.sv =====
`timescale 1ns / 1ps
// ============================================================================
// reconnect_backoff_controller
// Link reconnect manager with capped exponential backoff.
// ============================================================================
// One event per input transaction (connect, user disconnect, link up, link
// down, link error, 1 ms tick) gives one result transaction. An event passes
// an input register, is evaluated against the reconnect state, and lands in
// an output register; a new event is accepted every cycle while the output
// side keeps up. The retry delay is min(base << attempts, cap). Configuration
// is written through the cfg channel, which is always ready.
// ============================================================================
module reconnect_backoff_controller
    import rbc_pkg::*;
#(
    parameter int DELAY_BITS   = 20,
    parameter int ATTEMPT_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Event stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] func, [3] link_open
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] open_link, [1] close_link, [2] notify_up, [3] notify_down,
    // [4] notify_error, [5] retry_armed, [25:6] retry_delay,
    // [33:26] attempt_count, [34] waiting
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t              cfg;
    result_t           core_result;

    logic              in_v_reg;
    logic [FUNC_W-1:0] in_func_reg;
    logic              in_open_reg;
    logic              out_v_reg;
    result_t           out_data_reg;

    logic              out_take;
    logic              fire;
    logic              in_take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    rbc_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline flow control
    assign out_take = !out_v_reg || m_tready;
    assign fire     = in_v_reg && out_take;
    assign s_tready = !in_v_reg || out_take;
    assign in_take  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (s_tready)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= s_tdata[FUNC_W-1:0];
            in_open_reg <= s_tdata[FUNC_W];
        end
    end

    // Event evaluation
    rbc_event_core #(
        .DELAY_BITS   (DELAY_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .func      (in_func_reg),
        .link_open (in_open_reg),
        .result    (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_take)
            out_v_reg <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= core_result;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_data_reg};

    // Checks
    a_armed_waits: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_data_reg.retry_armed |-> out_data_reg.waiting)
        else $error("armed retry without running countdown");

    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_data_reg.retry_armed |-> out_data_reg.retry_delay == '0)
        else $error("retry delay nonzero without arming");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_v_reg)
        else $error("processed event did not reach result register");

endmodule

// ===== hw/rtl/rbc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rbc_cfg_regs
// Configuration register file: backoff base, backoff cap, channel attach.
// ============================================================================
module rbc_cfg_regs
    import rbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_BASE:   cfg_next.base     = wr_data[BASE_W-1:0];
                REG_CAP:    cfg_next.cap      = wr_data[CAP_W-1:0];
                REG_ATTACH: cfg_next.attached = wr_data[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base     <= BASE_RESET;
            cfg_reg.cap      <= CAP_RESET;
            cfg_reg.attached <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/rbc_event_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rbc_event_core
// Reconnect state and per-event logic: backoff delay, countdown, attempts.
// ============================================================================
module rbc_event_core
    import rbc_pkg::*;
#(
    parameter int DELAY_BITS   = 20,
    parameter int ATTEMPT_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              fire,
    input  logic [FUNC_W-1:0] func,
    input  logic              link_open,
    output result_t           result
);

    localparam logic [SHIFT_W-1:0] DelayMax =
        (SHIFT_W'(1) << DELAY_BITS) - SHIFT_W'(1);

    logic                    user_closed_reg, user_closed_next;
    logic [ATTEMPT_BITS-1:0] attempts_reg, attempts_next;
    logic                    running_reg, running_next;
    logic [DELAY_BITS-1:0]   ticks_left_reg, ticks_left_next;

    logic [31:0]             att_ext;
    logic [SHIFT_W-1:0]      shifted;
    logic [SHIFT_W-1:0]      cap_ext;
    logic [SHIFT_W-1:0]      delay_raw;
    logic [SHIFT_W-1:0]      delay_clip;
    logic [31:0]             att_out_ext;

    // Backoff delay: min(base << attempts, cap), limited to the counter range;
    // a zero base always gives a zero delay
    always_comb
    begin
        att_ext   = 32'(attempts_reg);
        shifted   = SHIFT_W'(cfg.base) << att_ext[4:0];
        cap_ext   = SHIFT_W'(cfg.cap);
        if (cfg.base == '0)
            delay_raw = '0;
        else if (att_ext >= 32'd32 || shifted > cap_ext)
            delay_raw = cap_ext;
        else
            delay_raw = shifted;
        delay_clip = (delay_raw > DelayMax) ? DelayMax : delay_raw;
    end

    // Event decode and next state
    always_comb
    begin
        user_closed_next = user_closed_reg;
        attempts_next    = attempts_reg;
        running_next     = running_reg;
        ticks_left_next  = ticks_left_reg;
        result           = '0;

        if (cfg.attached)
        begin
            case (func_t'(func))
                FUNC_CONNECT:
                begin
                    if (!link_open)
                    begin
                        user_closed_next = 1'b0;
                        running_next     = 1'b0;
                        attempts_next    = '0;
                        result.open_link = 1'b1;
                    end
                end
                FUNC_USER_DISC:
                begin
                    user_closed_next  = 1'b1;
                    running_next      = 1'b0;
                    result.close_link = link_open;
                end
                FUNC_LINK_UP:
                begin
                    running_next     = 1'b0;
                    attempts_next    = '0;
                    result.notify_up = 1'b1;
                end
                FUNC_LINK_DOWN:
                begin
                    result.notify_down = 1'b1;
                    if (!user_closed_reg && !running_reg)
                    begin
                        running_next       = 1'b1;
                        ticks_left_next    = delay_clip[DELAY_BITS-1:0];
                        result.retry_armed = 1'b1;
                        result.retry_delay = delay_clip[OUT_DELAY_W-1:0];
                    end
                end
                FUNC_LINK_ERROR:
                begin
                    result.notify_error = 1'b1;
                    if (!user_closed_reg && !link_open && !running_reg)
                    begin
                        running_next       = 1'b1;
                        ticks_left_next    = delay_clip[DELAY_BITS-1:0];
                        result.retry_armed = 1'b1;
                        result.retry_delay = delay_clip[OUT_DELAY_W-1:0];
                    end
                end
                FUNC_TICK:
                begin
                    if (running_reg)
                    begin
                        if (ticks_left_reg <= DELAY_BITS'(1))
                        begin
                            // countdown expired: retry
                            ticks_left_next  = '0;
                            running_next     = 1'b0;
                            if (attempts_reg != {ATTEMPT_BITS{1'b1}})
                                attempts_next = attempts_reg + ATTEMPT_BITS'(1);
                            result.open_link = 1'b1;
                        end
                        else
                        begin
                            ticks_left_next = ticks_left_reg - DELAY_BITS'(1);
                        end
                    end
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end

        att_out_ext          = 32'(attempts_next);
        result.attempt_count = att_out_ext[OUT_ATT_W-1:0];
        result.waiting       = running_next;
    end

    // State registers, updated once per processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_closed_reg <= 1'b0;
            attempts_reg    <= '0;
            running_reg     <= 1'b0;
            ticks_left_reg  <= '0;
        end
        else if (fire)
        begin
            user_closed_reg <= user_closed_next;
            attempts_reg    <= attempts_next;
            running_reg     <= running_next;
            ticks_left_reg  <= ticks_left_next;
        end
    end

endmodule

// ===== sim/reconnect_backoff_controller_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// reconnect_backoff_controller_tb
// Self-checking bench for the reconnect backoff controller.
// ============================================================================
// Link events stream in through a driver fed from a queue. Each accepted
// event runs through a local model of the reconnect state: user-closed flag,
// attempt count and retry countdown. The expected result is queued, and the
// monitor checks every result transaction field by field. The configuration
// is rewritten between phases while the block is idle. The phases cover
// detached operation, zero and maximum base and cap, a saturated attempt
// count and random event mixes. Both stream sides stall in random bursts,
// and one long output hold-off backs the pipeline up into the input.
// ============================================================================
module reconnect_backoff_controller_tb;
    import rbc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    // Codes outside the event set; the block treats them as no-ops
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    // One event transaction, packed as it sits in s_tdata
    typedef struct packed {
        logic              lopen;
        logic [FUNC_W-1:0] code;
    } ev_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Stimulus and scoreboard
    ev_t     event_q[$];
    result_t result_q[$];
    int      err_cnt     = 0;
    int      cycle_cnt   = 0;
    bit      ev_taken    = 1'b0;
    bit      cfg_taken   = 1'b0;
    bit      quiet       = 1'b0;
    bit      hold_req    = 1'b0;
    bit      hold_started = 1'b0;
    int      hold_left   = 0;
    int      gap_left    = 0;
    int      stall_left  = 0;

    // Model of the configuration and reconnect state
    logic [BASE_W-1:0]      base_m    = BASE_RESET;
    logic [CAP_W-1:0]       cap_m     = CAP_RESET;
    logic                   attach_m  = 1'b0;
    logic                   closed_m  = 1'b0;
    logic [OUT_ATT_W-1:0]   att_m     = '0;
    logic                   running_m = 1'b0;
    logic [OUT_DELAY_W-1:0] left_m    = '0;

    reconnect_backoff_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Start the countdown with min(base << attempts, cap); returns the delay
    function automatic logic [OUT_DELAY_W-1:0] arm_countdown();
        logic [63:0] d;
        if (base_m == '0)
            d = '0;
        else if (att_m >= 8'd32)
            d = 64'(cap_m);
        else
        begin
            d = 64'(base_m) << att_m;
            if (d > 64'(cap_m))
                d = 64'(cap_m);
        end
        left_m    = d[OUT_DELAY_W-1:0];
        running_m = 1'b1;
        return d[OUT_DELAY_W-1:0];
    endfunction

    // Advance the reconnect state by one event and build its result
    function automatic result_t step_reconnect(input ev_t e);
        result_t r;
        r = '0;
        if (attach_m)
        begin
            case (e.code)
                FUNC_CONNECT:
                    if (!e.lopen)
                    begin
                        closed_m    = 1'b0;
                        running_m   = 1'b0;
                        att_m       = '0;
                        r.open_link = 1'b1;
                    end
                FUNC_USER_DISC:
                begin
                    closed_m     = 1'b1;
                    running_m    = 1'b0;
                    r.close_link = e.lopen;
                end
                FUNC_LINK_UP:
                begin
                    running_m   = 1'b0;
                    att_m       = '0;
                    r.notify_up = 1'b1;
                end
                FUNC_LINK_DOWN:
                begin
                    r.notify_down = 1'b1;
                    if (!closed_m && !running_m)
                    begin
                        r.retry_armed = 1'b1;
                        r.retry_delay = arm_countdown();
                    end
                end
                FUNC_LINK_ERROR:
                begin
                    r.notify_error = 1'b1;
                    if (!closed_m && !e.lopen && !running_m)
                    begin
                        r.retry_armed = 1'b1;
                        r.retry_delay = arm_countdown();
                    end
                end
                FUNC_TICK:
                    if (running_m)
                    begin
                        // Expiry on the last tick, or at once for a zero delay
                        if (left_m <= 1)
                        begin
                            left_m    = '0;
                            running_m = 1'b0;
                            if (att_m != '1)
                                att_m = att_m + 1'b1;
                            r.open_link = 1'b1;
                        end
                        else
                            left_m = left_m - 1'b1;
                    end
                default: ;
            endcase
        end
        r.attempt_count = att_m;
        r.waiting       = running_m;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Monitor: predicts on accepted events, checks result transactions
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            ev_taken  = s_tvalid && s_tready;
            cfg_taken = cfg_valid && cfg_ready;
            if (cfg_taken)
            begin
                case (cfg_index)
                    REG_BASE:   base_m   = cfg_data[BASE_W-1:0];
                    REG_CAP:    cap_m    = cfg_data[CAP_W-1:0];
                    REG_ATTACH: attach_m = cfg_data[0];
                    default: ;
                endcase
            end
            if (ev_taken)
                result_q.push_back(step_reconnect(ev_t'(s_tdata[3:0])));
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (result_q.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, 0);
                else
                begin
                    want = result_q.pop_front();
                    if (got.open_link !== want.open_link)
                        report_mismatch("open_link", got.open_link, want.open_link);
                    if (got.close_link !== want.close_link)
                        report_mismatch("close_link", got.close_link, want.close_link);
                    if (got.notify_up !== want.notify_up)
                        report_mismatch("notify_up", got.notify_up, want.notify_up);
                    if (got.notify_down !== want.notify_down)
                        report_mismatch("notify_down", got.notify_down, want.notify_down);
                    if (got.notify_error !== want.notify_error)
                        report_mismatch("notify_error", got.notify_error, want.notify_error);
                    if (got.retry_armed !== want.retry_armed)
                        report_mismatch("retry_armed", got.retry_armed, want.retry_armed);
                    if (got.retry_delay !== want.retry_delay)
                        report_mismatch("retry_delay", got.retry_delay, want.retry_delay);
                    if (got.attempt_count !== want.attempt_count)
                        report_mismatch("attempt_count", got.attempt_count,
                                        want.attempt_count);
                    if (got.waiting !== want.waiting)
                        report_mismatch("waiting", got.waiting, want.waiting);
                end
            end
        end
    end

    // Event driver: next transaction once the current one is taken
    always @(negedge clk)
    begin
        ev_t e;
        if (rst_n && (!s_tvalid || ev_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                e = event_q.pop_front();
                s_tdata  <= {4'b0000, e};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result-side ready: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_event(input logic [FUNC_W-1:0] code, input logic lopen);
        event_q.push_back('{lopen: lopen, code: code});
    endtask

    // Weighted mix of all event codes, link state random
    task automatic push_random(input int count);
        int unsigned p;
        logic [FUNC_W-1:0] code;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 40)
                code = FUNC_TICK;
            else if (p < 55)
                code = FUNC_LINK_DOWN;
            else if (p < 70)
                code = FUNC_LINK_ERROR;
            else if (p < 78)
                code = FUNC_LINK_UP;
            else if (p < 86)
                code = FUNC_CONNECT;
            else if (p < 94)
                code = FUNC_USER_DISC;
            else if (p < 97)
                code = FUNC_SPARE_LO;
            else
                code = FUNC_SPARE_HI;
            push_event(code, 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until all events are taken and all results checked
    task automatic wait_drained();
        while (event_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_timing(input logic [BASE_W-1:0] base, input logic [CAP_W-1:0] cap);
        write_reg(REG_BASE, CFG_DATA_W'(base));
        write_reg(REG_CAP, cap);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Out of reset nothing is attached: all events ignored
        push_event(FUNC_CONNECT, 1'b0);
        push_event(FUNC_LINK_DOWN, 1'b0);
        push_event(FUNC_TICK, 1'b0);
        push_event(FUNC_LINK_UP, 1'b1);
        wait_drained();

        // Reset timing values, every event kind and the user-closed path
        write_reg(REG_ATTACH, 20'd1);
        push_event(FUNC_LINK_DOWN, 1'b0);
        push_event(FUNC_LINK_ERROR, 1'b0);
        push_event(FUNC_TICK, 1'b1);
        push_event(FUNC_LINK_UP, 1'b1);
        push_event(FUNC_LINK_ERROR, 1'b1);
        push_event(FUNC_LINK_ERROR, 1'b0);
        push_event(FUNC_USER_DISC, 1'b1);
        push_event(FUNC_LINK_DOWN, 1'b1);
        push_event(FUNC_LINK_ERROR, 1'b0);
        push_event(FUNC_CONNECT, 1'b1);
        push_event(FUNC_CONNECT, 1'b0);
        push_event(FUNC_SPARE_LO, 1'b1);
        push_event(FUNC_SPARE_HI, 1'b0);
        push_event(FUNC_TICK, 1'b0);
        wait_drained();

        // Zero base: zero delay, expiry on the next tick
        set_timing('0, '1);
        push_event(FUNC_LINK_DOWN, 1'b0);
        push_event(FUNC_TICK, 1'b0);
        push_event(FUNC_LINK_DOWN, 1'b1);
        push_event(FUNC_TICK, 1'b1);
        wait_drained();

        // Zero cap, then a large shift below the maximum cap
        set_timing('1, '0);
        push_event(FUNC_LINK_DOWN, 1'b0);
        push_event(FUNC_TICK, 1'b0);
        wait_drained();
        write_reg(REG_CAP, '1);
        push_event(FUNC_LINK_DOWN, 1'b0);
        push_event(FUNC_LINK_UP, 1'b1);
        wait_drained();

        // Short delays so countdowns expire; long output hold-off
        set_timing(BASE_W'($urandom_range(1, 4)), CAP_W'($urandom_range(1, 64)));
        push_random(250);
        hold_req = 1'b1;
        wait_drained();

        // Minimum timing and retry after retry: attempt count saturates
        set_timing(16'd1, 20'd1);
        push_event(FUNC_CONNECT, 1'b0);
        for (int i = 0; i < 270; i++)
        begin
            if ($urandom_range(0, 1) != 0)
                push_event(FUNC_LINK_DOWN, 1'($urandom_range(0, 1)));
            else
                push_event(FUNC_LINK_ERROR, 1'b0);
            push_event(FUNC_TICK, 1'($urandom_range(0, 1)));
        end
        wait_drained();

        // Maximum timing with the count saturated: delay is the cap
        set_timing('1, '1);
        push_event(FUNC_LINK_DOWN, 1'b0);
        push_event(FUNC_TICK, 1'b0);
        push_event(FUNC_LINK_ERROR, 1'b0);
        push_event(FUNC_LINK_UP, 1'b0);
        wait_drained();

        // Random timing across the full register ranges
        set_timing(BASE_W'($urandom_range(1, 65535)), CAP_W'($urandom_range(1, 1048575)));
        push_random(50);
        wait_drained();
        set_timing(BASE_W'($urandom_range(1, 65535)), CAP_W'($urandom_range(1, 1048575)));
        push_random(50);
        push_event(FUNC_CONNECT, 1'b0);
        push_event(FUNC_LINK_DOWN, 1'b0);
        wait_drained();

        // Detached with a countdown running: it stays frozen
        write_reg(REG_ATTACH, 20'd0);
        push_random(60);
        wait_drained();

        // Final stretch without idling on either side
        write_reg(REG_ATTACH, 20'd1);
        set_timing(BASE_W'($urandom_range(1, 8)), CAP_W'($urandom_range(1, 100)));
        quiet = 1'b1;
        push_random(120);
        wait_drained();

        repeat (8) @(negedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== reconnect_backoff_controller.f =====
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_cfg_regs.sv
hw/rtl/rbc_event_core.sv
hw/rtl/reconnect_backoff_controller.sv
sim/reconnect_backoff_controller_tb.sv
